// ===== rtl/hgp_pkg.sv =====
// Shared types, character codes and keyword tables for the HTTP GET request parser.
package hgp_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = 1;
    localparam int QUEUE_CNT_BITS  = 2;

    localparam logic [3:0] KW_GET_LEN    = 4'd3;
    localparam logic [3:0] KW_VER_LEN    = 4'd8;
    localparam logic [3:0] KW_SCHEME_LEN = 4'd7;
    localparam logic [3:0] KW_CONN_LEN   = 4'd11;
    localparam logic [3:0] KW_KEEP_LEN   = 4'd10;
    localparam logic [3:0] KW_CLEN_LEN   = 4'd15;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LOW_H = 8'h68;

    typedef enum logic [3:0] {
        PH_METHOD    = 4'd0,
        PH_URL_START = 4'd1,
        PH_URL       = 4'd2,
        PH_VERSION   = 4'd3,
        PH_HDR_NAME  = 4'd4,
        PH_HDR_WS    = 4'd5,
        PH_CONN_VAL  = 4'd6,
        PH_LEN_VAL   = 4'd7,
        PH_HDR_SKIP  = 4'd8,
        PH_CONTENT   = 4'd9
    } hgp_phase_t;

    typedef enum logic [1:0] {
        KIND_URL  = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2
    } hgp_kind_t;

    typedef enum logic [1:0] {
        URL_PATH   = 2'd0,
        URL_SCHEME = 2'd1,
        URL_HOST   = 2'd2
    } hgp_url_mode_t;

    // One classified request byte as it travels through the queue.
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] lower;
        logic       is_cr;
        logic       is_lf;
        logic       is_sep;
        logic       is_digit;
        logic       is_vt_ff;
        logic       is_plus;
        logic       is_minus;
        logic       is_slash;
    } hgp_item_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] kw_get_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return "g";
            4'd1:    return "e";
            4'd2:    return "t";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_ver_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return "h";
            4'd1:    return "t";
            4'd2:    return "t";
            4'd3:    return "p";
            4'd4:    return "/";
            4'd5:    return "1";
            4'd6:    return ".";
            4'd7:    return "1";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_scheme_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return "h";
            4'd1:    return "t";
            4'd2:    return "t";
            4'd3:    return "p";
            4'd4:    return ":";
            4'd5:    return "/";
            4'd6:    return "/";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_conn_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return "c";
            4'd1:    return "o";
            4'd2:    return "n";
            4'd3:    return "n";
            4'd4:    return "e";
            4'd5:    return "c";
            4'd6:    return "t";
            4'd7:    return "i";
            4'd8:    return "o";
            4'd9:    return "n";
            4'd10:   return ":";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_keep_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return "k";
            4'd1:    return "e";
            4'd2:    return "e";
            4'd3:    return "p";
            4'd4:    return "-";
            4'd5:    return "a";
            4'd6:    return "l";
            4'd7:    return "i";
            4'd8:    return "v";
            4'd9:    return "e";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_clen_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return "c";
            4'd1:    return "o";
            4'd2:    return "n";
            4'd3:    return "t";
            4'd4:    return "e";
            4'd5:    return "n";
            4'd6:    return "t";
            4'd7:    return "-";
            4'd8:    return "l";
            4'd9:    return "e";
            4'd10:   return "n";
            4'd11:   return "g";
            4'd12:   return "t";
            4'd13:   return "h";
            4'd14:   return ":";
            default: return 8'h00;
        endcase
    endfunction

endpackage

// ===== rtl/hgp_in_if.sv =====
// Handshake channel that carries one request byte per word.
interface hgp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/hgp_out_if.sv =====
// Handshake channel that carries one parser result per word.
interface hgp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  url_byte;
    logic        keep_alive;
    logic [31:0] body_length;

    modport source (output valid, output result_kind, output url_byte, output keep_alive,
                    output body_length, input ready);
    modport sink   (input valid, input result_kind, input url_byte, input keep_alive,
                    input body_length, output ready);
endinterface

// ===== rtl/hgp_front.sv =====
// Front end: accepts request bytes and classifies each one for the parser.
module hgp_front
    import hgp_pkg::*;
(
    hgp_in_if.sink    req,
    input  logic      q_full,
    output logic      push,
    output hgp_item_t push_item
);

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    always_comb
    begin
        push_item.raw      = req.in_byte;
        push_item.lower    = to_lower(req.in_byte);
        push_item.is_cr    = (req.in_byte == CH_CR);
        push_item.is_lf    = (req.in_byte == CH_LF);
        push_item.is_sep   = (req.in_byte == CH_SPACE) || (req.in_byte == CH_TAB);
        push_item.is_digit = (req.in_byte >= CH_ZERO) && (req.in_byte <= CH_NINE);
        push_item.is_vt_ff = (req.in_byte == CH_VT) || (req.in_byte == CH_FF);
        push_item.is_plus  = (req.in_byte == CH_PLUS);
        push_item.is_minus = (req.in_byte == CH_MINUS);
        push_item.is_slash = (req.in_byte == CH_SLASH);
    end

endmodule

// ===== rtl/hgp_queue.sv =====
// Short queue of classified bytes between the front end and the parser.
module hgp_queue
    import hgp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hgp_item_t push_item,
    input  logic      pop,
    output logic      q_valid,
    output logic      q_full,
    output hgp_item_t q_item
);

    hgp_item_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/hgp_back.sv =====
// Back end: request parser state machine with a registered result stage.
module hgp_back
    import hgp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  hgp_item_t q_item,
    output logic      pop,
    hgp_out_if.source res
);

    localparam int PROD_BITS = LENGTH_BITS + 4;

    hgp_phase_t             phase_reg;
    hgp_phase_t             phase_next;
    logic [3:0]             pos_reg;
    logic [3:0]             pos_next;
    logic [1:0]             hk_reg;
    logic [1:0]             hk_next;
    hgp_url_mode_t          um_reg;
    hgp_url_mode_t          um_next;
    logic                   cr_reg;
    logic                   cr_next;
    logic                   le_reg;
    logic                   le_next;
    logic                   vm_reg;
    logic                   vm_next;
    logic                   ka_reg;
    logic                   ka_next;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [LENGTH_BITS-1:0] len_next;
    logic [LENGTH_BITS-1:0] cnt_reg;
    logic [LENGTH_BITS-1:0] cnt_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    hgp_kind_t              kind_reg;
    logic [7:0]             ubyte_reg;
    logic                   keep_reg;
    logic [31:0]            blen_reg;

    logic                   fire;
    logic [LENGTH_BITS-1:0] cnt_plus;
    logic [PROD_BITS-1:0]   prod;
    logic [LENGTH_BITS-1:0] len_digit;
    logic [LENGTH_BITS+31:0] len_wide;
    logic                   req_line_fail;
    logic                   emit;
    hgp_kind_t              kind;
    logic [7:0]             ubyte;

    assign fire     = q_valid && (!out_valid_reg || res.ready);
    assign pop      = fire;
    assign cnt_plus = cnt_reg + 1'b1;
    assign len_wide = (LENGTH_BITS + 32)'(len_reg);

    // Decimal accumulation: len * 10 + digit, saturating at all ones.
    assign prod = (PROD_BITS'(len_reg) << 3) + (PROD_BITS'(len_reg) << 1)
                + PROD_BITS'(q_item.raw[3:0]);
    assign len_digit = (prod[PROD_BITS-1:LENGTH_BITS] != '0) ? '1 : prod[LENGTH_BITS-1:0];

    assign req_line_fail = le_reg || (phase_reg != PH_VERSION) || (pos_reg != KW_VER_LEN);

    // Next-state logic.
    always_comb
    begin
        logic       go_reset;
        logic       go_header;
        logic       do_conn;
        logic       do_len;
        logic [3:0] vpos;
        logic       vvm;
        logic [1:0] cand;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        hk_next    = hk_reg;
        um_next    = um_reg;
        cr_next    = cr_reg;
        le_next    = le_reg;
        vm_next    = vm_reg;
        ka_next    = ka_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        go_reset   = 1'b0;
        go_header  = 1'b0;
        do_conn    = 1'b0;
        do_len     = 1'b0;
        vpos       = pos_reg;
        vvm        = vm_reg;
        cand       = hk_reg;

        if (fire)
        begin
            if (phase_reg > PH_CONTENT)
            begin
                go_reset = 1'b1;
            end
            else if (phase_reg == PH_CONTENT)
            begin
                cnt_next = cnt_plus;
                if (cnt_plus >= len_reg)
                begin
                    go_reset = 1'b1;
                end
            end
            else if (cr_reg)
            begin
                cr_next = 1'b0;
                if (!q_item.is_lf)
                begin
                    go_reset = 1'b1;
                end
                else if (phase_reg <= PH_VERSION)
                begin
                    if (req_line_fail)
                    begin
                        go_reset = 1'b1;
                    end
                    else
                    begin
                        go_header = 1'b1;
                    end
                end
                else if (phase_reg == PH_HDR_NAME && pos_reg == 4'd0)
                begin
                    if (len_reg != '0)
                    begin
                        phase_next = PH_CONTENT;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        go_reset = 1'b1;
                    end
                end
                else
                begin
                    if (phase_reg == PH_CONN_VAL && vm_reg && pos_reg == KW_KEEP_LEN)
                    begin
                        ka_next = 1'b1;
                    end
                    go_header = 1'b1;
                end
            end
            else if (q_item.is_cr)
            begin
                cr_next = 1'b1;
            end
            else if (q_item.is_lf)
            begin
                go_reset = 1'b1;
            end
            else if (!(phase_reg <= PH_VERSION && le_reg))
            begin
                case (phase_reg)
                    PH_METHOD:
                    begin
                        if (pos_reg < KW_GET_LEN)
                        begin
                            if (q_item.lower == kw_get_char(pos_reg))
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                            else
                            begin
                                le_next = 1'b1;
                            end
                        end
                        else if (q_item.is_sep)
                        begin
                            phase_next = PH_URL_START;
                            pos_next   = 4'd0;
                        end
                        else
                        begin
                            le_next = 1'b1;
                        end
                    end
                    PH_URL_START:
                    begin
                        if (q_item.is_slash)
                        begin
                            um_next    = URL_PATH;
                            phase_next = PH_URL;
                        end
                        else if (q_item.lower == CH_LOW_H)
                        begin
                            um_next    = URL_SCHEME;
                            pos_next   = 4'd1;
                            phase_next = PH_URL;
                        end
                        else
                        begin
                            le_next = 1'b1;
                        end
                    end
                    PH_URL:
                    begin
                        if (um_reg == URL_PATH)
                        begin
                            if (q_item.is_sep)
                            begin
                                phase_next = PH_VERSION;
                                pos_next   = 4'd0;
                            end
                        end
                        else if (um_reg == URL_SCHEME)
                        begin
                            if (pos_reg < KW_SCHEME_LEN
                                && q_item.lower == kw_scheme_char(pos_reg))
                            begin
                                pos_next = pos_reg + 1'b1;
                                if (pos_reg + 1'b1 == KW_SCHEME_LEN)
                                begin
                                    um_next = URL_HOST;
                                end
                            end
                            else
                            begin
                                le_next = 1'b1;
                            end
                        end
                        else if (q_item.is_sep)
                        begin
                            le_next = 1'b1;
                        end
                        else if (q_item.is_slash)
                        begin
                            um_next = URL_PATH;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (pos_reg < KW_VER_LEN && q_item.lower == kw_ver_char(pos_reg))
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                        else
                        begin
                            le_next = 1'b1;
                        end
                    end
                    PH_HDR_NAME:
                    begin
                        if (cand[0] && (pos_reg >= KW_CONN_LEN
                            || q_item.lower != kw_conn_char(pos_reg)))
                        begin
                            cand[0] = 1'b0;
                        end
                        if (cand[1] && (pos_reg >= KW_CLEN_LEN
                            || q_item.lower != kw_clen_char(pos_reg)))
                        begin
                            cand[1] = 1'b0;
                        end
                        if (cand[0] && pos_reg + 1'b1 == KW_CONN_LEN)
                        begin
                            hk_next    = 2'd1;
                            phase_next = PH_HDR_WS;
                            pos_next   = 4'd0;
                        end
                        else if (cand[1] && pos_reg + 1'b1 == KW_CLEN_LEN)
                        begin
                            hk_next    = 2'd2;
                            phase_next = PH_HDR_WS;
                            pos_next   = 4'd0;
                            len_next   = '0;
                        end
                        else if (cand == 2'd0)
                        begin
                            hk_next    = 2'd0;
                            phase_next = PH_HDR_SKIP;
                        end
                        else
                        begin
                            hk_next  = cand;
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    PH_HDR_WS:
                    begin
                        // The first byte after the whitespace already belongs to the value.
                        if (!q_item.is_sep)
                        begin
                            vpos = 4'd0;
                            if (hk_reg == 2'd1)
                            begin
                                phase_next = PH_CONN_VAL;
                                vvm        = 1'b1;
                                do_conn    = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_LEN_VAL;
                                do_len     = 1'b1;
                            end
                        end
                    end
                    PH_CONN_VAL:
                    begin
                        do_conn = 1'b1;
                    end
                    PH_LEN_VAL:
                    begin
                        do_len = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                if (do_conn)
                begin
                    if (vvm && vpos < KW_KEEP_LEN && q_item.lower == kw_keep_char(vpos))
                    begin
                        pos_next = vpos + 1'b1;
                        vm_next  = 1'b1;
                    end
                    else
                    begin
                        pos_next = vpos;
                        vm_next  = 1'b0;
                    end
                end

                if (do_len)
                begin
                    if (vpos == 4'd0 && q_item.is_vt_ff)
                    begin
                        pos_next = vpos;
                    end
                    else if (vpos == 4'd0 && q_item.is_plus)
                    begin
                        pos_next = 4'd1;
                    end
                    else if (vpos == 4'd0 && q_item.is_minus)
                    begin
                        pos_next = 4'd2;
                    end
                    else if (vpos < 4'd2 && q_item.is_digit)
                    begin
                        len_next = len_digit;
                        pos_next = 4'd1;
                    end
                    else
                    begin
                        pos_next = 4'd2;
                    end
                end
            end

            if (go_header)
            begin
                phase_next = PH_HDR_NAME;
                pos_next   = 4'd0;
                hk_next    = 2'd3;
                vm_next    = 1'b0;
                le_next    = 1'b0;
            end

            if (go_reset)
            begin
                phase_next = PH_METHOD;
                pos_next   = 4'd0;
                hk_next    = 2'd0;
                um_next    = URL_PATH;
                cr_next    = 1'b0;
                le_next    = 1'b0;
                vm_next    = 1'b0;
                ka_next    = 1'b0;
                len_next   = '0;
                cnt_next   = '0;
            end
        end
    end

    // Result logic.
    always_comb
    begin
        emit  = 1'b0;
        kind  = KIND_URL;
        ubyte = 8'h00;

        if (fire && phase_reg <= PH_CONTENT)
        begin
            if (phase_reg == PH_CONTENT)
            begin
                if (cnt_plus >= len_reg)
                begin
                    emit = 1'b1;
                    kind = KIND_DONE;
                end
            end
            else if (cr_reg)
            begin
                if (!q_item.is_lf)
                begin
                    emit = 1'b1;
                    kind = KIND_BAD;
                end
                else if (phase_reg <= PH_VERSION)
                begin
                    if (req_line_fail)
                    begin
                        emit = 1'b1;
                        kind = KIND_BAD;
                    end
                end
                else if (phase_reg == PH_HDR_NAME && pos_reg == 4'd0 && len_reg == '0)
                begin
                    emit = 1'b1;
                    kind = KIND_DONE;
                end
            end
            else if (q_item.is_lf)
            begin
                emit = 1'b1;
                kind = KIND_BAD;
            end
            else if (!q_item.is_cr && !(phase_reg <= PH_VERSION && le_reg))
            begin
                if ((phase_reg == PH_URL_START && q_item.is_slash)
                    || (phase_reg == PH_URL && um_reg == URL_PATH && !q_item.is_sep)
                    || (phase_reg == PH_URL && um_reg != URL_PATH && um_reg != URL_SCHEME
                        && q_item.is_slash))
                begin
                    emit  = 1'b1;
                    kind  = KIND_URL;
                    ubyte = q_item.raw;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = emit;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_METHOD;
            pos_reg       <= 4'd0;
            hk_reg        <= 2'd0;
            um_reg        <= URL_PATH;
            cr_reg        <= 1'b0;
            le_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            ka_reg        <= 1'b0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            hk_reg        <= hk_next;
            um_reg        <= um_next;
            cr_reg        <= cr_next;
            le_reg        <= le_next;
            vm_reg        <= vm_next;
            ka_reg        <= ka_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            kind_reg  <= kind;
            ubyte_reg <= ubyte;
            keep_reg  <= (kind == KIND_DONE) ? ka_reg : 1'b0;
            blen_reg  <= (kind == KIND_DONE) ? len_wide[31:0] : 32'd0;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.result_kind = kind_reg;
    assign res.url_byte    = ubyte_reg;
    assign res.keep_alive  = keep_reg;
    assign res.body_length = blen_reg;

endmodule

// ===== rtl/http_get_request_parser.sv =====
// Top level of the HTTP GET request parser: front end, byte queue and parser back end.
// A byte accepted at req is written into a queue slot; the parser then steps on it from
// the queue and places any result word for it in the output register.
// Throughput: one byte per cycle while the back end's result register is free or is being taken.
// The two-entry queue absorbs two bytes while a result word waits at the output.
// Reset (rst_n, asynchronous, active low) returns the parser to expecting the method
// and empties the queue and the output register; there is no clearing pass.
module http_get_request_parser
    import hgp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    hgp_in_if.sink    req,
    hgp_out_if.source res
);

    // Classified bytes travel from the front end through the queue to the parser.
    logic      push;
    logic      pop;
    logic      q_valid;
    logic      q_full;
    hgp_item_t push_item;
    hgp_item_t q_item;

    // The front end takes a byte whenever the queue has room, so it never waits on the
    // parser directly.
    hgp_front u_front (
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // With two entries a push and a pop can happen in the same cycle at full rate,
    // and the input ready depends only on registered occupancy.
    hgp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .q_item    (q_item)
    );

    // The back end advances one byte whenever its result register is free or is being
    // taken. The Content-Length value accumulates as len * 10 + digit with saturation at
    // the all-ones value of LENGTH_BITS; the reported body_length is its low 32 bits.
    hgp_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .res     (res)
    );

endmodule
